@@ design/wipc_pkg.sv @@
// Shared types, constants and width helpers for the windowed-integral PID controller.
package wipc_pkg;

  localparam int DEF_WINDOW = 200;

  localparam int TEMP_W  = 16;
  localparam int GAIN_W  = 16;
  localparam int ERR_W   = TEMP_W + 1;
  localparam int DER_W   = ERR_W + 1;
  localparam int DRIVE_W = 7;
  localparam int FRAC_W  = 16;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [DRIVE_W-1:0] DRIVE_MAX = 7'd100;

  localparam logic signed [TEMP_W-1:0] RST_TARGET = 16'sd10368;
  localparam logic [GAIN_W-1:0]        RST_KP     = 16'd7680;
  localparam logic [GAIN_W-1:0]        RST_KI     = 16'd205;
  localparam logic [GAIN_W-1:0]        RST_KD     = 16'd5120;

  typedef enum logic [1:0] {
    REG_TARGET = 2'd0,
    REG_KP     = 2'd1,
    REG_KI     = 2'd2,
    REG_KD     = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] target;
    logic [GAIN_W-1:0]        kp;
    logic [GAIN_W-1:0]        ki;
    logic [GAIN_W-1:0]        kd;
  } cfg_t;

  // Width of the ring sum: WINDOW signed errors.
  function automatic int sum_width(input int window);
    return ERR_W + $clog2(window);
  endfunction

  // Width of the integral term: ring sum plus the current error.
  function automatic int int_width(input int window);
    return ERR_W + $clog2(window + 1);
  endfunction

endpackage

@@ design/wipc_in_if.sv @@
// Input channel carrying one measured temperature per item.
interface wipc_in_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [wipc_pkg::TEMP_W-1:0]        measured_temperature;

  modport source (output valid, output measured_temperature, input ready);
  modport sink   (input valid, input measured_temperature, output ready);
endinterface

@@ design/wipc_out_if.sv @@
// Result channel carrying one heater drive percentage per item.
interface wipc_out_if;
  logic                              valid;
  logic                              ready;
  logic [wipc_pkg::DRIVE_W-1:0]      drive_percent;

  modport source (output valid, output drive_percent, input ready);
  modport sink   (input valid, input drive_percent, output ready);
endinterface

@@ design/wipc_cfg_regs.sv @@
// APB-style register block holding the set point and the three loop gains.
module wipc_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [wipc_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [wipc_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [wipc_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready,
  output wipc_pkg::cfg_t                     cfg
);
  import wipc_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  logic     wr_en;
  reg_idx_t idx;

  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx        = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:2]);
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_TARGET: cfg_nxt.target = $signed(cfg_pwdata[TEMP_W-1:0]);
        REG_KP:     cfg_nxt.kp     = cfg_pwdata[GAIN_W-1:0];
        REG_KI:     cfg_nxt.ki     = cfg_pwdata[GAIN_W-1:0];
        REG_KD:     cfg_nxt.kd     = cfg_pwdata[GAIN_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TARGET: cfg_prdata = {{(CFG_DATA_W-TEMP_W){cfg_r.target[TEMP_W-1]}}, cfg_r.target};
      REG_KP:     cfg_prdata = {{(CFG_DATA_W-GAIN_W){1'b0}}, cfg_r.kp};
      REG_KI:     cfg_prdata = {{(CFG_DATA_W-GAIN_W){1'b0}}, cfg_r.ki};
      REG_KD:     cfg_prdata = {{(CFG_DATA_W-GAIN_W){1'b0}}, cfg_r.kd};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target <= RST_TARGET;
      cfg_r.kp     <= RST_KP;
      cfg_r.ki     <= RST_KI;
      cfg_r.kd     <= RST_KD;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ design/wipc_error_stage.sv @@
// Error, derivative and windowed integral with the error ring, feeding three gain products.
module wipc_error_stage #(
  parameter int WINDOW = wipc_pkg::DEF_WINDOW
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        up_valid,
  output logic                                        up_ready,
  input  logic signed [wipc_pkg::TEMP_W-1:0]          meas,
  input  wipc_pkg::cfg_t                              cfg,
  output logic                                        dn_valid,
  input  logic                                        dn_ready,
  output logic signed [wipc_pkg::int_width(WINDOW)+16:0] p_int,
  output logic signed [wipc_pkg::ERR_W+16:0]          p_prop,
  output logic signed [wipc_pkg::DER_W+16:0]          p_der
);
  import wipc_pkg::*;

  localparam int SUM_W = sum_width(WINDOW);
  localparam int INT_W = int_width(WINDOW);
  localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW - 1);

  logic signed [ERR_W-1:0] ring_mem [WINDOW];
  logic signed [ERR_W-1:0] rd_r;

  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic                    wrapped_r;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [ERR_W-1:0] prev_r;

  logic                    fire;
  logic signed [ERR_W-1:0] err;
  logic signed [DER_W-1:0] deriv;
  logic signed [INT_W-1:0] integ;
  logic signed [INT_W-1:0] sum_after;
  logic signed [ERR_W-1:0] oldest;

  logic                           v_r;
  logic signed [INT_W+16:0]       pi_r;
  logic signed [ERR_W+16:0]       pp_r;
  logic signed [DER_W+16:0]       pd_r;

  assign up_ready = !v_r || dn_ready;
  assign fire     = up_valid && up_ready;

  assign err   = {cfg.target[TEMP_W-1], cfg.target} - {meas[TEMP_W-1], meas};
  assign deriv = {err[ERR_W-1], err} - {prev_r[ERR_W-1], prev_r};
  assign integ = {{(INT_W-SUM_W){sum_r[SUM_W-1]}}, sum_r}
               + {{(INT_W-ERR_W){err[ERR_W-1]}}, err};

  // Entries not yet written in the first lap count as zero.
  assign oldest    = wrapped_r ? rd_r : '0;
  assign sum_after = integ - {{(INT_W-ERR_W){oldest[ERR_W-1]}}, oldest};
  assign pos_nxt   = (pos_r == POS_LAST) ? '0 : pos_r + 1'b1;

  always_ff @(posedge clk) begin
    if (fire) begin
      ring_mem[pos_r] <= err;
      // Fetch the entry the next item retires; a one-entry ring reads its own write.
      if (pos_nxt == pos_r) begin
        rd_r <= err;
      end else begin
        rd_r <= ring_mem[pos_nxt];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      wrapped_r <= 1'b0;
      sum_r     <= '0;
      prev_r    <= '0;
      v_r       <= 1'b0;
    end else begin
      if (fire) begin
        pos_r  <= pos_nxt;
        sum_r  <= sum_after[SUM_W-1:0];
        prev_r <= err;
        if (pos_r == POS_LAST) begin
          wrapped_r <= 1'b1;
        end
        v_r <= 1'b1;
      end else if (dn_ready) begin
        v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pi_r <= $signed({1'b0, cfg.ki}) * integ;
      pp_r <= $signed({1'b0, cfg.kp}) * err;
      pd_r <= $signed({1'b0, cfg.kd}) * deriv;
    end
  end

  assign dn_valid = v_r;
  assign p_int    = pi_r;
  assign p_prop   = pp_r;
  assign p_der    = pd_r;

endmodule

@@ design/wipc_drive_stage.sv @@
// Sums the three gain products, drops the fraction and clamps the drive to 0..100.
module wipc_drive_stage #(
  parameter int WINDOW = wipc_pkg::DEF_WINDOW
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           up_valid,
  output logic                                           up_ready,
  input  logic signed [wipc_pkg::int_width(WINDOW)+16:0] p_int,
  input  logic signed [wipc_pkg::ERR_W+16:0]             p_prop,
  input  logic signed [wipc_pkg::DER_W+16:0]             p_der,
  output logic                                           dn_valid,
  input  logic                                           dn_ready,
  output logic [wipc_pkg::DRIVE_W-1:0]                   drive
);
  import wipc_pkg::*;

  localparam int INT_W = int_width(WINDOW);
  localparam int PI_W  = INT_W + 17;
  localparam int PP_W  = ERR_W + 17;
  localparam int PD_W  = DER_W + 17;
  localparam int TOT_W = PI_W + 2;
  localparam int WH_W  = TOT_W - FRAC_W;

  logic signed [TOT_W-1:0] total;
  logic [WH_W-1:0]         whole;
  logic [DRIVE_W-1:0]      drive_nxt;
  logic                    v_r;
  logic [DRIVE_W-1:0]      drive_r;

  assign total = {{(TOT_W-PI_W){p_int[PI_W-1]}}, p_int}
               + {{(TOT_W-PP_W){p_prop[PP_W-1]}}, p_prop}
               + {{(TOT_W-PD_W){p_der[PD_W-1]}}, p_der};
  assign whole = total[TOT_W-1:FRAC_W];

  always_comb begin
    priority if (total[TOT_W-1] || (total == '0)) begin
      drive_nxt = '0;
    end else if (whole > WH_W'(DRIVE_MAX)) begin
      drive_nxt = DRIVE_MAX;
    end else begin
      drive_nxt = whole[DRIVE_W-1:0];
    end
  end

  assign up_ready = !v_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      drive_r <= drive_nxt;
    end
  end

  assign dn_valid = v_r;
  assign drive    = drive_r;

endmodule

@@ design/windowed_integral_pid_controller_unit.sv @@
// Top level of the windowed-integral PID heater controller.
//
// Each input item is one measured temperature (signed Q8.8 degrees) and yields exactly one
// result item, the heater drive in whole percent clamped to 0..100. The block takes one
// item per clock cycle while the result side keeps ready high, and returns its result
// through the input register, the gain-product register and the result register; the
// sustained rate of one item per cycle is set by the update of the window sum, the ring
// pointer and the previous error, which closes on itself once per item. The error history
// of WINDOW entries sits in a memory with one write and one registered read per cycle;
// the entry to be retired is fetched one item ahead, since the ring pointer only steps
// forward. No clearing pass follows reset: a lap flag makes entries not yet written in the
// first trip around the ring count as zero, so items are taken as soon as reset is released.
// Configuration is an APB-style port with target, proportional, integral and derivative gain
// at byte addresses 0, 4, 8 and 12; write it only while no item is in flight.

module windowed_integral_pid_controller_unit #(
  parameter int WINDOW = wipc_pkg::DEF_WINDOW
) (
  input  logic                               clk,
  input  logic                               rst_n,
  wipc_in_if.sink                            in_ch,
  wipc_out_if.source                         out_ch,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [wipc_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [wipc_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [wipc_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready
);
  import wipc_pkg::*;

  localparam int INT_W = int_width(WINDOW);

  cfg_t cfg;

  // Input register: the item waits here until the error stage can take it.
  logic                     in_v_r;
  logic signed [TEMP_W-1:0] meas_r;
  logic                     es_ready;

  // Registered gain products between the error stage and the drive stage.
  logic                     prod_valid;
  logic                     ds_ready;
  logic signed [INT_W+16:0] p_int;
  logic signed [ERR_W+16:0] p_prop;
  logic signed [DER_W+16:0] p_der;

  assign in_ch.ready = !in_v_r || es_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      meas_r <= in_ch.measured_temperature;
    end
  end

  wipc_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // The controller state advances when an item moves from the input register into this stage.
  wipc_error_stage #(
    .WINDOW (WINDOW)
  ) u_err (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_v_r),
    .up_ready (es_ready),
    .meas     (meas_r),
    .cfg      (cfg),
    .dn_valid (prod_valid),
    .dn_ready (ds_ready),
    .p_int    (p_int),
    .p_prop   (p_prop),
    .p_der    (p_der)
  );

  // The result register sits in the drive stage; the ready path through it is combinational.
  wipc_drive_stage #(
    .WINDOW (WINDOW)
  ) u_drive (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (prod_valid),
    .up_ready (ds_ready),
    .p_int    (p_int),
    .p_prop   (p_prop),
    .p_der    (p_der),
    .dn_valid (out_ch.valid),
    .dn_ready (out_ch.ready),
    .drive    (out_ch.drive_percent)
  );

endmodule

@@ design/wipc_checker.sv @@
// Port-level assertions for the controller and the bind that attaches them.
module wipc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [wipc_pkg::DRIVE_W-1:0]  out_drive
);
  import wipc_pkg::*;

  // A result never exceeds full duty.
  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_drive <= DRIVE_MAX))
    else $error("drive above full duty");

  // A result waiting on the sink keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_drive)))
    else $error("waiting result changed or vanished");

  // Reset leaves no result on the port.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // With the sink ready, every stage moves, so the input side is never blocked.
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ready && in_valid) |-> in_ready)
    else $error("input blocked while the result side is ready");

endmodule

bind windowed_integral_pid_controller_unit wipc_checker u_wipc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_drive (out_ch.drive_percent)
);
